// File: hdl/fader_position_to_gain_assert.svh
// assertion macros shared by the fader position to gain modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef FADER_POSITION_TO_GAIN_ASSERT_SVH
`define FADER_POSITION_TO_GAIN_ASSERT_SVH

// same-cycle implication
`define FPG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fpg_pkg.sv
// constants, tables and types for the fader position to gain pipeline
// no dependencies; used by fpg_level, fpg_gain and fader_position_to_gain
package fpg_pkg;

  // fader position
  localparam int PosFracBits = 16;
  localparam int PosW        = 17;
  localparam int InTdataW    = 24;
  localparam int FullTravel  = 1 << PosFracBits;

  // knot table: fraction of travel in permille, level in Q8 dB, tangent in Q8 dB per travel
  localparam int KnotCount = 5;
  localparam int NumSeg    = KnotCount - 1;
  localparam int SegW      = 2;
  localparam int KnotPermille [KnotCount] = '{50, 250, 500, 750, 1000};
  localparam int KnotDbQ8     [KnotCount] = '{-15360, -6144, -2048, 0, 1536};
  localparam int KnotSlopeQ8  [KnotCount] = '{46080, 24606, 10923, 7022, 6144};

  // level range
  localparam int LevelW    = 16;
  localparam int LvlW      = LevelW + 2;
  localparam int FloorDbQ8 = -30720;
  localparam int MaxDbQ8   = 1536;

  // horner evaluation, values scaled by the permille scale
  localparam int HornerScale = 1000;
  localparam int SW          = 16;
  localparam int SFracW      = 16;
  localparam int HalfS       = 1 << (SFracW - 1);
  localparam int AccW        = 32;
  localparam int ProdW       = AccW + SW + 1;

  function automatic int knot_pos(int k);
    return (KnotPermille[k] * FullTravel + HornerScale / 2) / HornerScale;
  endfunction

  localparam int KnotPos [KnotCount] = '{knot_pos(0), knot_pos(1), knot_pos(2), knot_pos(3),
                                         knot_pos(4)};
  localparam int SegX0 [NumSeg] = '{knot_pos(0), knot_pos(1), knot_pos(2), knot_pos(3)};
  // 2^16 / segment width: first segment is 13107 wide, 5 * 13107 = 65535 makes x5 exact,
  // the others are a quarter of travel
  localparam int SegScale [NumSeg] = '{5, 4, 4, 4};

  // final divide by the horner scale is done on a biased, nonnegative numerator
  localparam int CubOff  = 32768;
  localparam int CubBias = CubOff * HornerScale + HornerScale / 2;
  localparam int CubDiv  = HornerScale;

  function automatic int seg_t0(int i);
    return KnotSlopeQ8[i] * (KnotPermille[i+1] - KnotPermille[i]);
  endfunction

  function automatic int seg_t1(int i);
    return KnotSlopeQ8[i+1] * (KnotPermille[i+1] - KnotPermille[i]);
  endfunction

  function automatic int seg_c3(int i);
    return seg_t0(i) + seg_t1(i) - 2 * HornerScale * (KnotDbQ8[i+1] - KnotDbQ8[i]);
  endfunction

  function automatic int seg_c2(int i);
    return 3 * HornerScale * (KnotDbQ8[i+1] - KnotDbQ8[i]) - 2 * seg_t0(i) - seg_t1(i);
  endfunction

  function automatic int seg_c0off(int i);
    return HornerScale * KnotDbQ8[i] + CubBias;
  endfunction

  localparam int SegC3 [NumSeg] = '{seg_c3(0), seg_c3(1), seg_c3(2), seg_c3(3)};
  localparam int SegC2 [NumSeg] = '{seg_c2(0), seg_c2(1), seg_c2(2), seg_c2(3)};
  localparam int SegC1 [NumSeg] = '{seg_t0(0), seg_t0(1), seg_t0(2), seg_t0(3)};
  localparam int SegC0Off [NumSeg] = '{seg_c0off(0), seg_c0off(1), seg_c0off(2),
                                       seg_c0off(3)};

  // linear ramp below the first knot: floor((2*p*rise + x0) / (2*x0))
  localparam int LinMul  = 2 * (KnotDbQ8[0] - FloorDbQ8);
  localparam int LinBias = knot_pos(0);
  localparam int LinDiv  = 2 * knot_pos(0);
  localparam int LinOff  = -FloorDbQ8;

  // shared constant divider: reciprocal multiply plus one correction step
  localparam int NumW       = 27;
  localparam int RecW       = 31;
  localparam int MulW       = NumW + RecW;
  localparam int RecipShift = 40;
  localparam longint LinRecip = (longint'(1) << RecipShift) / LinDiv;
  localparam longint CubRecip = (longint'(1) << RecipShift) / CubDiv;
  localparam int DivW       = 13;
  localparam int QW         = 17;

  // gain
  localparam int GainFracBits = 16;
  localparam int GainW        = 17;
  localparam int GainMax      = (1 << GainW) - 1;
  localparam int UnityGain    = 1 << GainFracBits;
  localparam int OutTdataW    = 40;
  localparam int Log2K        = 2786635;  // log2(10)/20 in Q24
  localparam int LogFracW     = 16;
  localparam int XW           = 40;
  localparam int EW           = XW - LogFracW;
  localparam int NW           = 6;
  localparam int ExpSteps     = 16;
  localparam int MantFrac     = 30;
  localparam int MantW        = 32;
  localparam int TblW         = 31;
  localparam int ShW          = 6;
  localparam int RndW         = MantW + 3;

  // round(2^(2^-j) * 2^30) for j = 1..16
  localparam logic [TblW-1:0] ExpTbl [ExpSteps] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
    31'd1075196443, 31'd1074468887, 31'd1074105294, 31'd1073923544,
    31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
  };

  typedef logic [SegW-1:0] seg_t;

  typedef struct packed {
    logic lin;
    logic top;
    logic mute;
    seg_t seg;
  } ctl_t;

  typedef struct packed {
    logic                     mute;
    logic signed [LevelW-1:0] level;
  } meta_t;

endpackage

// File: hdl/fpg_level.sv
// position to level pipeline: segment select, horner cubic, shared constant divider
// depends on fpg_pkg and fader_position_to_gain_assert.svh
`include "fader_position_to_gain_assert.svh"

module fpg_level (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [fpg_pkg::PosW-1:0]  pos_i,
  output logic                      vld_o,
  output fpg_pkg::meta_t            meta_o
);
  import fpg_pkg::*;

  localparam int NumStg = 12;

  logic [NumStg-1:0] vld_q;
  ctl_t              ctl_q [NumStg-1];
  ctl_t              ctl_d;

  logic [PosW-1:0]        p_sat, p1_q, d2;
  logic [SW-1:0]          s_d, s_q [5];
  logic [NumW-1:0]        ln_d, ln_q [6];
  logic signed [AccW-1:0] c3, cub8;
  logic signed [SW:0]     s3x, s5x, s7x;
  logic signed [ProdW-1:0] prod1_d, prod1_q, prod2_d, prod2_q, prod3_d, prod3_q;
  logic signed [AccW-1:0] acc1_d, acc1_q, acc2_d, acc2_q;
  logic [NumW-1:0]        num_d, num_q [3];
  logic [RecW-1:0]        recip9;
  logic [MulW-1:0]        pr_d, pr_q;
  logic [QW-1:0]          qe_d, qe_q, q_d, q_q;
  logic [DivW-1:0]        div11;
  logic [NumW-1:0]        r11;
  logic signed [LvlW-1:0] lvl12;
  meta_t                  meta_d, meta_q;

  // stage 1: saturate and classify
  always_comb begin
    p_sat = (pos_i > PosW'(FullTravel)) ? PosW'(FullTravel) : pos_i;
    ctl_d.mute = (p_sat == '0);
    ctl_d.lin  = (p_sat <= PosW'(KnotPos[0]));
    ctl_d.top  = (p_sat == PosW'(FullTravel));
    ctl_d.seg  = '0;
    for (int k = 1; k < NumSeg; k++) begin
      if (p_sat >= PosW'(KnotPos[k])) begin
        ctl_d.seg = SegW'(k);
      end
    end
  end

  // stage 2: local coordinate s in Q16 and linear numerator
  always_comb begin
    d2   = p1_q - PosW'(SegX0[ctl_q[0].seg]);
    s_d  = SW'(d2 * PosW'(SegScale[ctl_q[0].seg]));
    ln_d = NumW'(NumW'(p1_q) * NumW'(LinMul)) + NumW'(LinBias);
  end

  // stages 3 to 8: horner steps, one multiply or one round-and-add per stage
  always_comb begin
    c3      = AccW'(SegC3[ctl_q[1].seg]);
    s3x     = {1'b0, s_q[0]};
    prod1_d = c3 * s3x;
    acc1_d  = AccW'((prod1_q + ProdW'(HalfS)) >>> SFracW) + AccW'(SegC2[ctl_q[2].seg]);
    s5x     = {1'b0, s_q[2]};
    prod2_d = acc1_q * s5x;
    acc2_d  = AccW'((prod2_q + ProdW'(HalfS)) >>> SFracW) + AccW'(SegC1[ctl_q[4].seg]);
    s7x     = {1'b0, s_q[4]};
    prod3_d = acc2_q * s7x;
    cub8    = AccW'((prod3_q + ProdW'(HalfS)) >>> SFracW) + AccW'(SegC0Off[ctl_q[6].seg]);
    num_d   = ctl_q[6].lin ? ln_q[5] : NumW'(cub8);
  end

  // stages 9 to 11: divide by the ramp or horner constant
  always_comb begin
    recip9 = ctl_q[7].lin ? RecW'(LinRecip) : RecW'(CubRecip);
    pr_d   = MulW'(num_q[0]) * MulW'(recip9);
    qe_d   = QW'(pr_q >> RecipShift);
    div11  = ctl_q[9].lin ? DivW'(LinDiv) : DivW'(CubDiv);
    r11    = num_q[2] - NumW'(qe_q) * NumW'(div11);
    q_d    = qe_q + QW'(r11 >= NumW'(div11));
  end

  // stage 12: remove bias, clamp, override ends
  always_comb begin
    lvl12 = signed'(LvlW'(q_q))
          - (ctl_q[10].lin ? LvlW'(LinOff) : LvlW'(CubOff));
    if (lvl12 < LvlW'(FloorDbQ8)) begin
      lvl12 = LvlW'(FloorDbQ8);
    end else if (lvl12 > LvlW'(MaxDbQ8)) begin
      lvl12 = LvlW'(MaxDbQ8);
    end
    meta_d.mute  = ctl_q[10].mute;
    meta_d.level = LevelW'(lvl12);
    if (ctl_q[10].top) begin
      meta_d.level = LevelW'(MaxDbQ8);
    end
    if (ctl_q[10].mute) begin
      meta_d.level = LevelW'(FloorDbQ8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStg-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q[0] <= ctl_d;
      for (int k = 1; k < NumStg - 1; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
      p1_q    <= p_sat;
      s_q[0]  <= s_d;
      for (int k = 1; k < 5; k++) begin
        s_q[k] <= s_q[k-1];
      end
      ln_q[0] <= ln_d;
      for (int k = 1; k < 6; k++) begin
        ln_q[k] <= ln_q[k-1];
      end
      prod1_q  <= prod1_d;
      acc1_q   <= acc1_d;
      prod2_q  <= prod2_d;
      acc2_q   <= acc2_d;
      prod3_q  <= prod3_d;
      num_q[0] <= num_d;
      num_q[1] <= num_q[0];
      num_q[2] <= num_q[1];
      pr_q     <= pr_d;
      qe_q     <= qe_d;
      q_q      <= q_d;
      meta_q   <= meta_d;
    end
  end

  assign vld_o  = vld_q[NumStg-1];
  assign meta_o = meta_q;

  `FPG_ASSERT_IMPL(a_level_range, vld_o, (meta_o.level >= LevelW'(FloorDbQ8)) && (meta_o.level <= LevelW'(MaxDbQ8)), "level out of range")
  `FPG_ASSERT_IMPL(a_mute_floor, vld_o && meta_o.mute, meta_o.level == LevelW'(FloorDbQ8), "muted request not at floor level")
  `FPG_ASSERT_NEXT(a_stall_hold, !en_i, $stable(vld_q), "pipeline moved while stalled")

endmodule

// File: hdl/fpg_gain.sv
// level to linear gain pipeline: log2 scaling, sixteen bitwise exp2 multiply stages,
// rounding shift; depends on fpg_pkg and fader_position_to_gain_assert.svh
`include "fader_position_to_gain_assert.svh"

module fpg_gain (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  fpg_pkg::meta_t             meta_i,
  output logic                       vld_o,
  output fpg_pkg::meta_t             meta_o,
  output logic [fpg_pkg::GainW-1:0]  gain_o
);
  import fpg_pkg::*;

  localparam int NumStg = ExpSteps + 3;

  logic [NumStg-1:0]        vld_q;
  meta_t                    meta_q [NumStg];
  logic signed [XW-1:0]     x_d, x_q;
  logic signed [EW-1:0]     e2;
  logic [LogFracW-1:0]      f_q [ExpSteps+1];
  logic signed [NW-1:0]     n_q [ExpSteps+1];
  logic [MantW-1:0]         mant_src [ExpSteps];
  logic [MantW-1:0]         mant_d [ExpSteps];
  logic [MantW-1:0]         mant_q [ExpSteps];
  logic signed [NW:0]       sh_s;
  logic [ShW-1:0]           shu;
  logic [RndW-1:0]          rnd;
  logic [GainW-1:0]         gain_d, gain_q;

  assign x_d = XW'(meta_i.level) * XW'(Log2K);
  assign e2  = EW'((x_q + XW'(1 << (LogFracW - 1))) >>> LogFracW);

  assign mant_src[0] = MantW'(1) << MantFrac;

  for (genvar j = 0; j < ExpSteps; j++) begin : g_step
    logic [MantW+TblW-1:0] prod;
    if (j > 0) begin : g_link
      assign mant_src[j] = mant_q[j-1];
    end
    // fraction bit weights 2^-(j+1), msb first
    always_comb begin
      prod = (MantW+TblW)'(mant_src[j]) * (MantW+TblW)'(ExpTbl[j]);
      mant_d[j] = f_q[j][LogFracW-1-j]
                ? MantW'((prod + (MantW+TblW)'(1 << (MantFrac - 1))) >> MantFrac)
                : mant_src[j];
    end
  end

  // scale by 2^n and round to the gain fraction
  always_comb begin
    sh_s   = (NW+1)'(MantFrac - GainFracBits) - (NW+1)'(n_q[ExpSteps]);
    shu    = ShW'(sh_s);
    rnd    = (RndW'(mant_q[ExpSteps-1]) + (RndW'(1) << (shu - ShW'(1)))) >> shu;
    gain_d = (rnd > RndW'(GainMax)) ? GainW'(GainMax) : GainW'(rnd);
    if (meta_q[NumStg-2].mute) begin
      gain_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumStg-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta_i;
      for (int k = 1; k < NumStg; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      x_q    <= x_d;
      f_q[0] <= e2[LogFracW-1:0];
      n_q[0] <= e2[LogFracW+NW-1:LogFracW];
      for (int k = 1; k <= ExpSteps; k++) begin
        f_q[k] <= f_q[k-1];
        n_q[k] <= n_q[k-1];
      end
      for (int k = 0; k < ExpSteps; k++) begin
        mant_q[k] <= mant_d[k];
      end
      gain_q <= gain_d;
    end
  end

  assign vld_o  = vld_q[NumStg-1];
  assign meta_o = meta_q[NumStg-1];
  assign gain_o = gain_q;

  `FPG_ASSERT_IMPL(a_mute_gain, vld_o && meta_o.mute, gain_o == '0, "muted request with nonzero gain")
  `FPG_ASSERT_IMPL(a_unity, vld_o && !meta_o.mute && !meta_o.level[LevelW-1], gain_o >= GainW'(UnityGain), "gain below unity at nonnegative level")

endmodule

// File: hdl/fader_position_to_gain.sv
// 12 level stages, then 19 gain stages, from input request to result
// one request per cycle when not stalled; the 16 chained exp2 multiplies set the depth
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset
// top level: stream ports around fpg_level and fpg_gain; depends on fpg_pkg
module fader_position_to_gain (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fpg_pkg::InTdataW-1:0]   s_axis_tdata,   // [16:0] position
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [fpg_pkg::OutTdataW-1:0]  m_axis_tdata,   // [15:0] level_db, [32:16] gain
  output logic                           m_axis_tuser    // [0] mute
);
  import fpg_pkg::*;

  logic             en;
  logic             lvl_vld;
  meta_t            lvl_meta;
  meta_t            out_meta;
  logic [GainW-1:0] out_gain;

  // last stage is the output register, so the pipe moves when it is empty or taken
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  fpg_level u_level (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .pos_i  (s_axis_tdata[PosW-1:0]),
    .vld_o  (lvl_vld),
    .meta_o (lvl_meta)
  );

  fpg_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (lvl_vld),
    .meta_i (lvl_meta),
    .vld_o  (m_axis_tvalid),
    .meta_o (out_meta),
    .gain_o (out_gain)
  );

  assign m_axis_tdata = {{(OutTdataW - GainW - LevelW){1'b0}}, out_gain, out_meta.level};
  assign m_axis_tuser = out_meta.mute;

endmodule

// File: tb/sv/testbench.sv
// stream testbench for fader_position_to_gain: directed corners, random positions and bursts
// each result is checked against a local model of the knot curve and the exp2 gain
// depends on fpg_pkg for the port widths
module testbench;

  localparam int InW  = fpg_pkg::InTdataW;
  localparam int OutW = fpg_pkg::OutTdataW;
  localparam int PosW = fpg_pkg::PosW;

  localparam longint FullTravel = 65536;
  localparam longint FloorLevel = -30720;
  localparam longint TopLevel   = 1536;
  localparam longint GainTop    = 131071;
  localparam longint Log2Scale  = 2786635;  // log2(10)/20 in Q24
  localparam int     TailCycles = 64;

  localparam longint CurvePermille [5] = '{50, 250, 500, 750, 1000};
  localparam longint CurveLevel    [5] = '{-15360, -6144, -2048, 0, 1536};
  localparam longint CurveSlope    [5] = '{46080, 24606, 10923, 7022, 6144};

  // round(2^(2^-j) * 2^30), j = 1..16
  localparam longint unsigned Exp2Step [16] = '{
    1518500250, 1276901417, 1170923762, 1121280436,
    1097253708, 1085434106, 1079572136, 1076653033,
    1075196443, 1074468887, 1074105294, 1073923544,
    1073832680, 1073787251, 1073764537, 1073753181
  };

  typedef struct {
    logic signed [15:0] level;
    logic [16:0]        gain;
    logic               mute;
  } fader_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic            m_axis_tuser;

  fader_result_t pending_results[$];
  fader_result_t oldest;
  int            err_count = 0;
  bit            stalls_on = 1'b1;
  int            ready_left = 0;
  int            rx_stall;

  fader_position_to_gain dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  // floor(a / d + 1/2) for d > 0
  function automatic longint round_half_up(input longint a, input longint d);
    longint num, den;
    num = 2 * a + d;
    den = 2 * d;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic longint knot_x(input int k);
    return (CurvePermille[k] * FullTravel + 500) / 1000;
  endfunction

  function automatic longint travel_to_level(input longint p);
    longint x0, x1, h, s, hp, t0, t1, dl, acc;
    int     seg;
    if (p >= FullTravel) return CurveLevel[4];
    x0 = knot_x(0);
    if (p <= x0) return FloorLevel + round_half_up(p * (CurveLevel[0] - FloorLevel), x0);
    seg = 0;
    while (seg < 3 && p >= knot_x(seg + 1)) seg++;
    x0 = knot_x(seg);
    x1 = knot_x(seg + 1);
    h  = x1 - x0;
    s  = ((p - x0) << 16) / h;
    if (s > 65535) s = 65535;
    hp = CurvePermille[seg + 1] - CurvePermille[seg];
    t0 = CurveSlope[seg] * hp;
    t1 = CurveSlope[seg + 1] * hp;
    dl = CurveLevel[seg + 1] - CurveLevel[seg];
    // hermite polynomial by horner, everything scaled by 1000
    acc = t0 + t1 - 2000 * dl;
    acc = round_half_up(acc * s, 65536) + (3000 * dl - 2 * t0 - t1);
    acc = round_half_up(acc * s, 65536) + t0;
    acc = round_half_up(acc * s, 65536) + 1000 * CurveLevel[seg];
    return round_half_up(acc, 1000);
  endfunction

  function automatic longint level_to_gain(input longint db);
    longint            e16, n;
    logic [15:0]       frac;
    longint unsigned   mant;
    int                sh;
    e16  = (db * Log2Scale + 32768) >>> 16;
    n    = e16 >>> 16;
    frac = e16[15:0];
    mant = 64'd1 << 30;
    for (int j = 1; j <= 16; j++) begin
      if (frac[16 - j]) mant = (mant * Exp2Step[j - 1] + (64'd1 << 29)) >> 30;
    end
    sh = 14 - int'(n);
    if (sh < 1) return GainTop;
    if (sh > 62) return 0;
    mant = (mant + (64'd1 << (sh - 1))) >> sh;
    return (mant > GainTop) ? GainTop : longint'(mant);
  endfunction

  function automatic fader_result_t fader_response(input logic [PosW-1:0] pos);
    fader_result_t r;
    longint        p, db;
    p = pos;
    if (p > FullTravel) p = FullTravel;
    db = travel_to_level(p);
    if (db < FloorLevel) db = FloorLevel;
    if (db > TopLevel) db = TopLevel;
    if (p == 0) begin
      r.level = FloorLevel[15:0];
      r.gain  = '0;
      r.mute  = 1'b1;
    end else begin
      r.level = db[15:0];
      r.gain  = 17'(level_to_gain(db));
      r.mute  = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- handshakes

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (!stalls_on) begin
      m_axis_tready <= 1'b1;
      ready_left    <= 0;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (m_axis_tready) begin
      rx_stall = pick_gap();
      if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        ready_left    <= rx_stall - 1;
      end else begin
        ready_left <= $urandom_range(0, 30);
      end
    end else begin
      m_axis_tready <= 1'b1;
      ready_left    <= $urandom_range(0, 40);
    end
  end

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      err_count++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t unexpected result: expected none, actual level %0d gain %0d mute %0d",
                 $time, $signed(m_axis_tdata[15:0]), m_axis_tdata[32:16], m_axis_tuser);
      end else begin
        oldest = pending_results.pop_front();
        report_field("level_db", oldest.level, $signed(m_axis_tdata[15:0]));
        report_field("gain", oldest.gain, m_axis_tdata[32:16]);
        report_field("mute", oldest.mute, m_axis_tuser);
      end
    end
  end

  // called just after a rising edge; returns at the edge where the request is taken
  task automatic send_position(input logic [PosW-1:0] pos);
    int gap;
    gap = stalls_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InW - PosW){1'b0}}, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(fader_response(pos));
  endtask

  // valid is already low when nothing is pending
  task automatic wait_drained();
    if (pending_results.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end
  endtask

  function automatic logic [PosW-1:0] random_position();
    int     r;
    longint k;
    r = $urandom_range(0, 99);
    if (r < 25) return PosW'($urandom_range(0, 131071));
    if (r < 35) return PosW'($urandom_range(0, 3278));
    if (r < 47) begin
      k = knot_x($urandom_range(0, 4)) + $urandom_range(0, 16) - 8;
      return k[PosW-1:0];
    end
    if (r < 49) return '0;
    return PosW'($urandom_range(1, 65536));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_corners();
    int corner [] = '{0, 1, 2, 3276, 3277, 3278, 16383, 16384, 16385, 24576, 32767, 32768,
                      32769, 40000, 49151, 49152, 49153, 65535, 65536, 65537, 98304,
                      131071, 1638};
    foreach (corner[i]) send_position(PosW'(corner[i]));
    wait_drained();
  endtask

  // drain pauses land at the midpoint and at random points of the stream
  task automatic test_random_travel(input int count);
    for (int i = 0; i < count; i++) begin
      send_position(random_position());
      if (i == count / 2 || $urandom_range(0, 149) == 0) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_streaming_no_stalls(input int count);
    stalls_on = 1'b0;
    for (int i = 0; i < count; i++) send_position(random_position());
    wait_drained();
    stalls_on = 1'b1;
  endtask

  task automatic test_knot_neighborhood(input int count);
    longint k;
    for (int i = 0; i < count; i++) begin
      k = knot_x($urandom_range(0, 4)) + $urandom_range(0, 64) - 32;
      send_position(k[PosW-1:0]);
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_corners();
    test_random_travel(1400);
    test_streaming_no_stalls(250);
    test_knot_neighborhood(250);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
